FILE: rtl/qlh_pkg.sv
// shared types, constants and helpers for the latency histogram
package qlh_pkg;

  // table and histogram sizes
  localparam int TAG_SLOTS    = 1024;
  localparam int BUCKET_COUNT = 27;
  localparam int TAG_W        = $clog2(TAG_SLOTS);
  localparam int BKT_W        = $clog2(BUCKET_COUNT);

  // port widths
  localparam int REQ_W      = 2;
  localparam int IN_TAG_W   = 10;
  localparam int BKT_PORT_W = 5;
  localparam int TS_W       = 64;
  localparam int CNT_W      = 32;
  localparam int STATUS_W   = 3;

  // timestamp table word: valid bit over the start time
  localparam int SLOT_W = TS_W + 1;

  // front queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // latency scaling
  localparam int US_DIVISOR = 1000;
  localparam int MS_DIVISOR = 1000000;
  localparam int THR_W      = 2 * TS_W;

  // request codes on req_type
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_START,
    OP_STOP,
    OP_READ,
    OP_NONE
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_STARTED   = 3'd0,
    STS_COUNTED   = 3'd1,
    STS_NO_START  = 3'd2,
    STS_NEG_DROP  = 3'd3,
    STS_READ_DATA = 3'd4
  } status_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_BIN
  } back_state_t;

  // classified item in the front queue
  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  now;
    logic [BKT_W-1:0] idx;
  } item_t;

  // one result transfer
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [BKT_W-1:0] bucket;
    logic [CNT_W-1:0] count;
  } result_t;

  // lower edge of bucket k in nanoseconds: divisor times two to the k
  function automatic logic [THR_W-1:0] lat_thresh(input logic ms, input int k);
    logic [THR_W-1:0] base;
    base = ms ? THR_W'(MS_DIVISOR) : THR_W'(US_DIVISOR);
    return base << k;
  endfunction

endpackage

FILE: rtl/queue_latency_log2_histogram_top.sv
// Flow: every transfer in is queued; start, read and unused requests give their result strobe
// from the idle state; a stop request after table read, subtract, compare, count update.
// The back end answers start/read/unused when idle and steps a stop through lookup, check, bin;
// a 2-entry queue in front lets start take a new item each cycle until it fills (busy high).
// Reset: synchronous; afterwards a pass over every tag slot clears the tag table, busy stays high.
// The histogram and mode register clear at once; results cannot be stalled by the receiver.
module queue_latency_log2_histogram_top import qlh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [IN_TAG_W-1:0]   packet_tag,
  input  logic [TS_W-1:0]       timestamp_ns,
  input  logic [BKT_PORT_W-1:0] bucket_index,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  output logic                  done,
  output logic [STATUS_W-1:0]   status,
  output logic [BKT_PORT_W-1:0] bucket,
  output logic [CNT_W-1:0]      count
);

  logic    millisecond_mode;
  logic    item_valid;
  item_t   item;
  logic    item_pop;
  logic    clearing;
  result_t res;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      millisecond_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      millisecond_mode <= cfg_wr_data;
    end
  end

  // request intake and queue
  qlh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .packet_tag  (packet_tag),
    .timestamp_ns(timestamp_ns),
    .bucket_index(bucket_index),
    .clearing    (clearing),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop)
  );

  // table, binning and histogram
  qlh_back u_back (
    .clk             (clk),
    .rst             (rst),
    .millisecond_mode(millisecond_mode),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop),
    .clearing        (clearing),
    .res             (res)
  );

  // result transfer
  assign done   = res.valid;
  assign status = res.status;
  assign bucket = BKT_PORT_W'(res.bucket);
  assign count  = res.count;

endmodule

FILE: rtl/qlh_ram.sv
// generic simple dual port ram with registered read
module qlh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/qlh_front.sv
// front end: takes requests, classifies them and queues them for the back end
module qlh_front import qlh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [IN_TAG_W-1:0]   packet_tag,
  input  logic [TS_W-1:0]       timestamp_ns,
  input  logic [BKT_PORT_W-1:0] bucket_index,
  input  logic                  clearing,
  output logic                  item_valid,
  output item_t                 item,
  input  logic                  item_pop
);

  item_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               push;
  logic               pop;
  item_t              cls;

  // classify the incoming request
  always_comb begin
    cls.tag = packet_tag[TAG_W-1:0];
    cls.now = timestamp_ns;
    if (int'(bucket_index) >= BUCKET_COUNT) begin
      cls.idx = BKT_W'(BUCKET_COUNT - 1);
    end else begin
      cls.idx = BKT_W'(bucket_index);
    end
    case (req_type)
      REQ_START: cls.op = OP_START;
      REQ_STOP:  cls.op = OP_STOP;
      REQ_READ:  cls.op = OP_READ;
      default:   cls.op = OP_NONE;
    endcase
  end

  // queue handshake
  assign busy       = clearing || (fill == QFILL_W'(QUEUE_DEPTH));
  assign push       = start && !busy;
  assign item_valid = (fill != '0);
  assign pop        = item_pop && item_valid;
  assign item       = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTH
  // a lone transfer in grows the queue by one
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1))
    else $error("queue fill did not grow on transfer in");

  // nothing is taken in during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    $past(clearing) && clearing |-> $stable(wr_ptr))
    else $error("queue written during clearing pass");
`endif

endmodule

FILE: rtl/qlh_back.sv
// back end: timestamp table, latency binning and histogram counters
module qlh_back import qlh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    millisecond_mode,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_pop,
  output logic    clearing,
  output result_t res
);

  back_state_t             state;
  back_state_t             state_next;
  item_t                   cur;
  logic [TS_W-1:0]         diff;
  logic [BUCKET_COUNT-2:0] therm;
  logic [CNT_W-1:0]        counts [BUCKET_COUNT];
  logic [TAG_W-1:0]        clr_addr;
  result_t                 res_next;

  logic                    ram_we;
  logic [TAG_W-1:0]        ram_waddr;
  logic [SLOT_W-1:0]       ram_wdata;
  logic                    ram_re;
  logic [TAG_W-1:0]        ram_raddr;
  logic [SLOT_W-1:0]       ram_rdata;

  logic                    load_cur;
  logic                    load_diff;
  logic                    load_therm;
  logic                    cnt_we;
  logic [BKT_W-1:0]        bin_bucket;
  logic [CNT_W-1:0]        cnt_inc;
  logic [BUCKET_COUNT-2:0] therm_next;

  // timestamp table: valid bit and start time per tag
  qlh_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TAG_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // latency against each bucket edge, one independent compare per bucket above the first
  always_comb begin
    for (int k = 1; k < BUCKET_COUNT; k++) begin
      therm_next[k-1] = ({{(THR_W - TS_W){1'b0}}, diff} >= lat_thresh(millisecond_mode, k));
    end
  end

  // bucket from the thermometer code and its incremented count
  assign bin_bucket = BKT_W'($countones(therm));
  assign cnt_inc    = counts[bin_bucket] + 1'b1;
  assign clearing   = (state == S_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == TAG_W'(TAG_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid && item.op == OP_STOP) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = ram_rdata[SLOT_W-1] ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        state_next = diff[TS_W-1] ? S_IDLE : S_BIN;
      end
      S_BIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    item_pop   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cur.tag;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = item.tag;
    load_cur   = 1'b0;
    load_diff  = 1'b0;
    load_therm = 1'b0;
    cnt_we     = 1'b0;
    res_next   = '{valid: 1'b0, status: STS_NO_START, bucket: '0, count: '0};
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          case (item.op)
            OP_START: begin
              ram_we          = 1'b1;
              ram_waddr       = item.tag;
              ram_wdata       = {1'b1, item.now};
              res_next.valid  = 1'b1;
              res_next.status = STS_STARTED;
            end
            OP_STOP: begin
              ram_re   = 1'b1;
              load_cur = 1'b1;
            end
            OP_READ: begin
              res_next.valid  = 1'b1;
              res_next.status = STS_READ_DATA;
              res_next.bucket = item.idx;
              res_next.count  = counts[item.idx];
            end
            default: begin
              res_next.valid  = 1'b1;
              res_next.status = STS_NO_START;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (ram_rdata[SLOT_W-1]) begin
          // close the entry and take the difference
          ram_we    = 1'b1;
          load_diff = 1'b1;
        end else begin
          res_next.valid  = 1'b1;
          res_next.status = STS_NO_START;
        end
      end
      S_CHECK: begin
        if (diff[TS_W-1]) begin
          res_next.valid  = 1'b1;
          res_next.status = STS_NEG_DROP;
        end else begin
          load_therm = 1'b1;
        end
      end
      S_BIN: begin
        cnt_we          = 1'b1;
        res_next.valid  = 1'b1;
        res_next.status = STS_COUNTED;
        res_next.bucket = bin_bucket;
        res_next.count  = cnt_inc;
      end
      default: begin
        res_next.valid = 1'b0;
      end
    endcase
  end

  // control state, histogram and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res.valid <= 1'b0;
      for (int i = 0; i < BUCKET_COUNT; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      res   <= res_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cnt_we) begin
        counts[bin_bucket] <= cnt_inc;
      end
    end
  end

  // item payload through the stop sequence
  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur <= item;
    end
    if (load_diff) begin
      diff <= cur.now - ram_rdata[TS_W-1:0];
    end
    if (load_therm) begin
      therm <= therm_next;
    end
  end

`ifndef SYNTH
  // binning always ends in a counted result
  assert property (@(posedge clk) disable iff (rst)
    (state == S_BIN) |=> (res.valid && res.status == STS_COUNTED))
    else $error("binning step gave no counted result");

  // the sign check only follows a table lookup
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ($past(state) == S_LOOK))
    else $error("sign check entered without lookup");

  // no result while the table is being cleared
  assert property (@(posedge clk) disable iff (rst)
    $past(state) == S_CLEAR |-> !res.valid)
    else $error("result during clearing pass");
`endif

endmodule

FILE: test/queue_latency_log2_histogram_top_tb.sv
// testbench for the queue latency log2 histogram: directed and random packet timing traffic
`timescale 1ns / 100ps

module queue_latency_log2_histogram_top_tb;
  import qlh_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 12;

  // one result transfer as the histogram should report it
  typedef struct packed {
    status_t               st;
    logic [BKT_PORT_W-1:0] bkt;
    logic [CNT_W-1:0]      cnt;
  } latency_answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [REQ_W-1:0]      req_type = '0;
  logic [IN_TAG_W-1:0]   packet_tag = '0;
  logic [TS_W-1:0]       timestamp_ns = '0;
  logic [BKT_PORT_W-1:0] bucket_index = '0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic [BKT_PORT_W-1:0] bucket;
  logic [CNT_W-1:0]      count;

  // mirror of the tag table, histogram and mode register
  logic             tag_live [TAG_SLOTS];
  logic [TS_W-1:0]  tag_time [TAG_SLOTS];
  logic [CNT_W-1:0] hist [BUCKET_COUNT];
  logic             ms_mode;

  latency_answer_t  latency_answers [$];
  int               mismatches = 0;
  int               burst_left = 0;

  // packets started by the random traffic and not yet stopped
  logic [IN_TAG_W-1:0] open_tags [$];
  logic [TS_W-1:0]     open_times [$];

  queue_latency_log2_histogram_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .packet_tag   (packet_tag),
    .timestamp_ns (timestamp_ns),
    .bucket_index (bucket_index),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .done         (done),
    .status       (status),
    .bucket       (bucket),
    .count        (count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // apply one request to the mirror and return its result
  function automatic latency_answer_t advance_latency_model(input logic [REQ_W-1:0] req,
                                                            input logic [IN_TAG_W-1:0] tag,
                                                            input logic [TS_W-1:0] now,
                                                            input logic [BKT_PORT_W-1:0] idx);
    latency_answer_t a;
    logic [TS_W-1:0] span;
    logic [TS_W-1:0] scaled;
    int b;
    a.st  = STS_NO_START;
    a.bkt = '0;
    a.cnt = '0;
    case (req)
      REQ_START: begin
        tag_time[tag] = now;
        tag_live[tag] = 1'b1;
        a.st = STS_STARTED;
      end
      REQ_STOP: begin
        if (tag_live[tag]) begin
          tag_live[tag] = 1'b0;
          span = now - tag_time[tag];
          if (span[TS_W-1]) begin
            a.st = STS_NEG_DROP;
          end else begin
            scaled = span / (ms_mode ? 64'(MS_DIVISOR) : 64'(US_DIVISOR));
            b = 0;
            while (scaled > 1) begin
              scaled = scaled >> 1;
              b++;
            end
            if (b > BUCKET_COUNT - 1) b = BUCKET_COUNT - 1;
            hist[b] = hist[b] + 1;
            a.st  = STS_COUNTED;
            a.bkt = BKT_PORT_W'(b);
            a.cnt = hist[b];
          end
        end
      end
      REQ_READ: begin
        b = (idx > BUCKET_COUNT - 1) ? BUCKET_COUNT - 1 : int'(idx);
        a.st  = STS_READ_DATA;
        a.bkt = BKT_PORT_W'(b);
        a.cnt = hist[b];
      end
      default: ;
    endcase
    return a;
  endfunction

  // check each result transfer, then record each accepted request
  always @(posedge clk) begin : track_results
    latency_answer_t want;
    if (rst) begin
      for (int i = 0; i < TAG_SLOTS; i++) tag_live[i] = 1'b0;
      for (int i = 0; i < BUCKET_COUNT; i++) hist[i] = '0;
      ms_mode = 1'b0;
    end else begin
      if (done === 1'b1) begin
        if (latency_answers.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status %0d bucket %0d count %0d",
                                  status, bucket, count));
        end else begin
          want = latency_answers.pop_front();
          if (status !== want.st)
            flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
          if (bucket !== want.bkt)
            flag_mismatch($sformatf("bucket %0d, want %0d", bucket, want.bkt));
          if (count !== want.cnt)
            flag_mismatch($sformatf("count %0d, want %0d", count, want.cnt));
        end
      end
      if (cfg_wr_en) ms_mode = cfg_wr_data;
      if (start && busy === 1'b0)
        latency_answers.push_back(advance_latency_model(req_type, packet_tag,
                                                        timestamp_ns, bucket_index));
    end
  end

  // end the run when transfers stop for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || done === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // drive one request, hold it until the transfer, then maybe take a gap
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [IN_TAG_W-1:0] tag,
                              input logic [TS_W-1:0] ts, input logic [BKT_PORT_W-1:0] idx);
    start        <= 1'b1;
    req_type     <= req;
    packet_tag   <= tag;
    timestamp_ns <= ts;
    bucket_index <= idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // long stretches now and then with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop sending and wait until every result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (latency_answers.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_mode(input logic ms);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ms;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // microsecond scaling corner cases
  task automatic test_directed_cases();
    send_request(REQ_READ, 10'd0, '0, 5'd0);
    send_request(REQ_READ, 10'd0, '0, 5'd26);
    // read index past the histogram saturates
    send_request(REQ_READ, 10'd1023, '1, 5'd31);
    // stop without a start
    send_request(REQ_STOP, 10'd5, 64'd1000, 5'd0);
    // unused request type
    send_request(REQ_UNUSED, 10'd5, '1, 5'd31);
    // below one microsecond
    send_request(REQ_START, 10'd0, 64'd0, 5'd0);
    send_request(REQ_STOP, 10'd0, 64'd999, 5'd0);
    send_request(REQ_START, 10'd1023, 64'd100, 5'd0);
    send_request(REQ_STOP, 10'd1023, 64'd2100, 5'd0);
    // repeat start overwrites the timestamp
    send_request(REQ_START, 10'd7, 64'd1000, 5'd0);
    send_request(REQ_START, 10'd7, 64'd5000, 5'd0);
    send_request(REQ_STOP, 10'd7, 64'd8000, 5'd0);
    // negative difference, then the tag is gone
    send_request(REQ_START, 10'd9, 64'd10000, 5'd0);
    send_request(REQ_STOP, 10'd9, 64'd5000, 5'd0);
    send_request(REQ_STOP, 10'd9, 64'd20000, 5'd0);
    // largest positive difference saturates the bucket
    send_request(REQ_START, 10'd3, 64'd0, 5'd0);
    send_request(REQ_STOP, 10'd3, 64'h7FFF_FFFF_FFFF_FFFF, 5'd0);
    // difference across the timestamp wrap is small and positive
    send_request(REQ_START, 10'd4, '1, 5'd0);
    send_request(REQ_STOP, 10'd4, 64'd0, 5'd0);
    // difference with only the sign bit set is negative
    send_request(REQ_START, 10'd6, 64'd0, 5'd0);
    send_request(REQ_STOP, 10'd6, 64'h8000_0000_0000_0000, 5'd0);
    // just under the last bucket
    send_request(REQ_START, 10'd2, 64'd5, 5'd0);
    send_request(REQ_STOP, 10'd2, 64'd5 + 64'd67108864000 - 64'd1, 5'd0);
    send_request(REQ_READ, 10'd0, '0, 5'd0);
  endtask

  // millisecond scaling corner cases
  task automatic test_millisecond_scaling();
    send_request(REQ_START, 10'd10, 64'd0, 5'd0);
    send_request(REQ_STOP, 10'd10, 64'd1999999, 5'd0);
    send_request(REQ_START, 10'd11, 64'd0, 5'd0);
    send_request(REQ_STOP, 10'd11, 64'd4000000, 5'd0);
    send_request(REQ_START, 10'd12, 64'd0, 5'd0);
    send_request(REQ_STOP, 10'd12, 64'h7FFF_FFFF_FFFF_FFFF, 5'd0);
    send_request(REQ_READ, 10'd0, '0, 5'd26);
  endtask

  // mostly start/stop pairs with latencies spread over all buckets
  task automatic test_random_traffic(input logic ms, input int n_items);
    int sent;
    int pick;
    int j;
    int k;
    logic [IN_TAG_W-1:0] tag;
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] lag;
    set_mode(ms);
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 || (open_tags.size() == 0 && pick < 75)) begin
        // start on a hot tag near either end of the table, or anywhere
        if ($urandom_range(0, 3) == 0) tag = IN_TAG_W'($urandom_range(0, TAG_SLOTS - 1));
        else tag = IN_TAG_W'($urandom_range(0, 15) + ($urandom_range(0, 1) ? 1008 : 0));
        ts = {$urandom, $urandom};
        open_tags.push_back(tag);
        open_times.push_back(ts);
        send_request(REQ_START, tag, ts, BKT_PORT_W'($urandom_range(0, 31)));
        sent++;
      end else if (pick < 80 && open_tags.size() != 0) begin
        j   = $urandom_range(0, open_tags.size() - 1);
        k   = $urandom_range(0, 62);
        lag = {$urandom, $urandom} >> (63 - k);
        if ($urandom_range(0, 9) == 0) lag = -lag;
        tag = open_tags[j];
        ts  = open_times[j] + lag;
        open_tags.delete(j);
        open_times.delete(j);
        send_request(REQ_STOP, tag, ts, BKT_PORT_W'($urandom_range(0, 31)));
        sent++;
      end else if (pick < 92) begin
        send_request(REQ_READ, IN_TAG_W'($urandom_range(0, TAG_SLOTS - 1)),
                     {$urandom, $urandom}, BKT_PORT_W'($urandom_range(0, 31)));
        sent++;
      end else if (pick < 96) begin
        // stop on an arbitrary tag, mostly never started
        send_request(REQ_STOP, IN_TAG_W'($urandom_range(0, TAG_SLOTS - 1)),
                     {$urandom, $urandom}, BKT_PORT_W'($urandom_range(0, 31)));
        sent++;
      end else begin
        send_request(REQ_UNUSED, IN_TAG_W'($urandom_range(0, TAG_SLOTS - 1)),
                     {$urandom, $urandom}, BKT_PORT_W'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin : sequencer
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_mode(1'b0);
    test_directed_cases();
    set_mode(1'b1);
    test_millisecond_scaling();
    test_random_traffic(1'b0, 200);
    test_random_traffic(1'b1, 200);
    test_random_traffic(1'b0, 200);
    test_random_traffic(1'b1, 200);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && latency_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
